/* rtl/e820_pkg.sv */
package e820_pkg;

  localparam int TABLE_ENTRIES = 128;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  localparam logic [63:0] HOLE_LOW  = 64'h0000_0000_000A_0000;
  localparam logic [63:0] HOLE_HIGH = 64'h0000_0000_0010_0000;
  localparam int PAGE_SHIFT = 12;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_ADD   = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NOP   = 2'd3
  } action_t;

  localparam logic [2:0] KIND_NONE     = 3'd0;
  localparam logic [2:0] KIND_RAM      = 3'd1;
  localparam logic [2:0] KIND_RESERVED = 3'd2;
  localparam logic [2:0] KIND_ACPI     = 3'd3;
  localparam logic [2:0] KIND_NVS      = 3'd4;

  typedef struct packed {
    logic [63:0] addr;
    logic [63:0] size;
    logic [2:0]  kind;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  function automatic logic [2:0] kind_of_type(input logic [3:0] efi_type);
    logic [2:0] kind;
    case (efi_type)
      4'd1, 4'd2, 4'd3, 4'd4, 4'd7: kind = KIND_RAM;
      4'd9: kind = KIND_ACPI;
      4'd10: kind = KIND_NVS;
      4'd14, 4'd15: kind = KIND_NONE;
      default: kind = KIND_RESERVED;
    endcase
    return kind;
  endfunction

endpackage

/* rtl/e820_ram.sv */
module map_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/efi_to_e820_map_builder_top.sv */
// Builds an e820 memory table from parsed firmware memory descriptors and answers one
// result transaction for every input transaction. A start transaction or an unused action
// passes straight to the result; a read fetches the addressed entry from the table memory;
// an add splits its region around the legacy hole, and a type that is dropped ends there.
// Each region it places (up to two) is written at once into an empty table, dropped when full,
// and otherwise written after the last entry is read back from the table memory. The next
// input transaction is taken once the current one has been handed to the output register,
// so a stalled output only holds the block after the following transaction is done.
module efi_to_e820_map_builder_top
  import e820_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [3:0]  in_efi_type,
  input  logic [63:0] in_physical_start,
  input  logic [51:0] in_num_pages,
  input  logic [7:0]  in_entry_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_entry_valid,
  output logic [63:0] out_entry_addr,
  output logic [63:0] out_entry_length,
  output logic [2:0]  out_entry_kind,
  output logic [7:0]  out_next_index,
  output logic        out_overflow,
  output logic [7:0]  out_entry_count
);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_SPLIT   = 7'b0000010,
    S_PLAN    = 7'b0000100,
    S_PUT_RD  = 7'b0001000,
    S_PUT_WR  = 7'b0010000,
    S_RD_DATA = 7'b0100000,
    S_FIN     = 7'b1000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [2:0]        kind_r, kind_nxt;
  logic [63:0]       start_r, start_nxt;
  logic [63:0]       size_r, size_nxt;
  logic [63:0]       end_r, end_nxt;
  logic [7:0]        idx_r, idx_nxt;
  logic              hole_r, hole_nxt;
  logic              lo_r, lo_nxt;
  logic              hi_r, hi_nxt;
  entry_t            cur_r, cur_nxt;
  logic              second_r, second_nxt;
  logic              dropped_r, dropped_nxt;
  logic              res_valid_r, res_valid_nxt;
  entry_t            res_entry_r, res_entry_nxt;
  logic [7:0]        res_next_r, res_next_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_entry_valid_r, out_entry_valid_nxt;
  entry_t            out_entry_r, out_entry_nxt;
  logic [7:0]        out_next_r, out_next_nxt;
  logic              out_overflow_r, out_overflow_nxt;
  logic [7:0]        out_count_r, out_count_nxt;

  logic              accept;
  logic              put_done;
  logic [63:0]       end_sum;
  logic [CNT_W-1:0]  cnt_m1;
  logic [8:0]        nxt_idx;
  entry_t            rd_q;
  logic              mem_we;
  logic              mem_re;
  logic [IDX_W-1:0]  mem_wa;
  logic [IDX_W-1:0]  mem_ra;
  entry_t            mem_wd;
  logic [ENTRY_W-1:0] mem_rd;

  map_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_table (
    .clk    (clk),
    .wr_en  (mem_we),
    .wr_addr(mem_wa),
    .wr_data(mem_wd),
    .rd_en  (mem_re),
    .rd_addr(mem_ra),
    .rd_data(mem_rd)
  );

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign rd_q     = entry_t'(mem_rd);
  assign cnt_m1   = count_r - CNT_W'(1);
  assign end_sum  = start_r + size_r;
  assign nxt_idx  = 9'(idx_r) + 9'd1;

  always_comb begin
    state_nxt           = state_r;
    count_nxt           = count_r;
    kind_nxt            = kind_r;
    start_nxt           = start_r;
    size_nxt            = size_r;
    end_nxt             = end_r;
    idx_nxt             = idx_r;
    hole_nxt            = hole_r;
    lo_nxt              = lo_r;
    hi_nxt              = hi_r;
    cur_nxt             = cur_r;
    second_nxt          = second_r;
    dropped_nxt         = dropped_r;
    res_valid_nxt       = res_valid_r;
    res_entry_nxt       = res_entry_r;
    res_next_nxt        = res_next_r;
    out_valid_nxt       = out_valid_r && !out_ready;
    out_entry_valid_nxt = out_entry_valid_r;
    out_entry_nxt       = out_entry_r;
    out_next_nxt        = out_next_r;
    out_overflow_nxt    = out_overflow_r;
    out_count_nxt       = out_count_r;
    mem_we              = 1'b0;
    mem_re              = 1'b0;
    mem_wa              = count_r[IDX_W-1:0];
    mem_ra              = cnt_m1[IDX_W-1:0];
    mem_wd              = cur_r;
    put_done            = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          kind_nxt      = kind_of_type(in_efi_type);
          start_nxt     = in_physical_start;
          size_nxt      = {in_num_pages, {PAGE_SHIFT{1'b0}}};
          idx_nxt       = in_entry_index;
          dropped_nxt   = 1'b0;
          res_valid_nxt = 1'b0;
          res_entry_nxt = '0;
          res_next_nxt  = '0;
          case (action_t'(in_action))
            ACT_START: begin
              count_nxt = '0;
              state_nxt = S_FIN;
            end
            ACT_ADD: begin
              state_nxt = S_SPLIT;
            end
            ACT_READ: begin
              mem_re    = 1'b1;
              mem_ra    = in_entry_index[IDX_W-1:0];
              state_nxt = S_RD_DATA;
            end
            default: begin
              state_nxt = S_FIN;
            end
          endcase
        end
      end
      S_SPLIT: begin
        end_nxt   = end_sum;
        hole_nxt  = (kind_r == KIND_RAM) && (start_r < HOLE_HIGH) && (end_sum > HOLE_LOW);
        lo_nxt    = (start_r < HOLE_LOW);
        hi_nxt    = (end_sum > HOLE_HIGH);
        state_nxt = (kind_r == KIND_NONE) ? S_FIN : S_PLAN;
      end
      S_PLAN: begin
        second_nxt = 1'b0;
        state_nxt  = S_PUT_RD;
        if (!hole_r) begin
          cur_nxt = '{addr: start_r, size: size_r, kind: kind_r};
        end else if (lo_r) begin
          cur_nxt    = '{addr: start_r, size: HOLE_LOW - start_r, kind: KIND_RAM};
          second_nxt = hi_r;
        end else if (hi_r) begin
          cur_nxt = '{addr: HOLE_HIGH, size: end_r - HOLE_HIGH, kind: KIND_RAM};
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_PUT_RD: begin
        if (count_r >= CNT_W'(TABLE_ENTRIES)) begin
          dropped_nxt = 1'b1;
          put_done    = 1'b1;
        end else if (count_r == '0) begin
          mem_we    = 1'b1;
          count_nxt = count_r + CNT_W'(1);
          put_done  = 1'b1;
        end else begin
          mem_re    = 1'b1;
          state_nxt = S_PUT_WR;
        end
      end
      S_PUT_WR: begin
        put_done = 1'b1;
        mem_we   = 1'b1;
        if ((rd_q.addr + rd_q.size == cur_r.addr) && (rd_q.kind == cur_r.kind)) begin
          mem_wa      = cnt_m1[IDX_W-1:0];
          mem_wd.addr = rd_q.addr;
          mem_wd.size = rd_q.size + cur_r.size;
          mem_wd.kind = rd_q.kind;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      S_RD_DATA: begin
        if (9'(idx_r) < 9'(count_r)) begin
          res_valid_nxt = 1'b1;
          res_entry_nxt = rd_q;
          res_next_nxt  = (nxt_idx < 9'(count_r)) ? nxt_idx[7:0] : 8'd0;
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt       = 1'b1;
          out_entry_valid_nxt = res_valid_r;
          out_entry_nxt       = res_entry_r;
          out_next_nxt        = res_next_r;
          out_overflow_nxt    = dropped_r;
          out_count_nxt       = 8'(count_r);
          state_nxt           = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (put_done) begin
      if (second_r) begin
        cur_nxt    = '{addr: HOLE_HIGH, size: end_r - HOLE_HIGH, kind: KIND_RAM};
        second_nxt = 1'b0;
        state_nxt  = S_PUT_RD;
      end else begin
        state_nxt = S_FIN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r            <= kind_nxt;
    start_r           <= start_nxt;
    size_r            <= size_nxt;
    end_r             <= end_nxt;
    idx_r             <= idx_nxt;
    hole_r            <= hole_nxt;
    lo_r              <= lo_nxt;
    hi_r              <= hi_nxt;
    cur_r             <= cur_nxt;
    second_r          <= second_nxt;
    dropped_r         <= dropped_nxt;
    res_valid_r       <= res_valid_nxt;
    res_entry_r       <= res_entry_nxt;
    res_next_r        <= res_next_nxt;
    out_entry_valid_r <= out_entry_valid_nxt;
    out_entry_r       <= out_entry_nxt;
    out_next_r        <= out_next_nxt;
    out_overflow_r    <= out_overflow_nxt;
    out_count_r       <= out_count_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_entry_valid  = out_entry_valid_r;
  assign out_entry_addr   = out_entry_r.addr;
  assign out_entry_length = out_entry_r.size;
  assign out_entry_kind   = out_entry_r.kind;
  assign out_next_index   = out_next_r;
  assign out_overflow     = out_overflow_r;
  assign out_entry_count  = out_count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_ENTRIES))
    else $error("entry count exceeds the table depth");

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_action == ACT_START) |=> (count_r == '0))
    else $error("start transaction did not clear the entry count");

  a_write_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (CNT_W'(mem_wa) <= count_r && count_r < CNT_W'(TABLE_ENTRIES) + CNT_W'(1)))
    else $error("table write beyond the next free entry");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |-> (count_r == $past(count_r) + CNT_W'(1) || count_r == '0))
    else $error("entry count changed by other than one append or a clear");

endmodule
